// ===== rtl/bpc_pkg.sv =====
// Shared types and constants for the button press classifier.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

  // Width of the timestamp arithmetic; differences wrap at this width.
  localparam int unsigned TIME_BITS = 32;
  // Width of the now_ms field on the input channel.
  localparam int unsigned NOW_BITS = 32;
  localparam int unsigned CFG_BITS = 16;
  localparam int unsigned TALLY_BITS = 8;

  localparam int unsigned IN_TDATA_BITS = ((1 + NOW_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_BITS = 8;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [TALLY_BITS-1:0] tally_t;
  typedef logic [CFG_BITS-1:0] cfg_word_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_LONG   = 2'd2,
    EV_DOUBLE = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    REG_DEBOUNCE      = 2'd0,
    REG_LONG_PRESS    = 2'd1,
    REG_DOUBLE_WINDOW = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_e;

  localparam cfg_word_t LONG_PRESS_RST    = 16'd1000;
  localparam cfg_word_t DOUBLE_WINDOW_RST = 16'd400;

  // One poll sample held in the input register.
  typedef struct packed {
    logic                pressed;
    logic [NOW_BITS-1:0] now_ms;
  } sample_t;

endpackage

`default_nettype wire

// ===== rtl/button_press_classifier_top.sv =====
// Top level of the button press classifier: input register and core.
// Depends on bpc_pkg, bpc_in_reg and bpc_core.
//
// Usage:
//   Slave channel s_axis_*: one poll sample per transfer (pressed level and
//   a free-running millisecond timestamp). Master channel m_axis_*: one
//   event code per sample (none, short, long or double press).
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
//   (1 long press, 2 double window); index 0 (debounce) and 3 are ignored.
//   Write only while no sample is in flight.
// Timing:
//   A sample passes through the input register and then the result register:
//   the input register holds the sample while the classification logic feeds
//   the result register. Throughput is one sample per cycle while the receiver
//   does not stall, set by the state update of the press tracker.
//   Reset clears the press state and sets the registers to 1000 and 400 ms.
//   When the receiver stalls, the result register holds and the input
//   register takes one more sample, after which s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module button_press_classifier_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [1:0]                          cfg_index_i,
  input  wire logic [bpc_pkg::CFG_BITS-1:0]        cfg_data_i,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [0] pressed, [32:1] now_ms, upper bits zero
  input  wire logic [bpc_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [1:0] event_code, upper bits zero
  output logic [bpc_pkg::OUT_TDATA_BITS-1:0]       m_axis_tdata
);
  import bpc_pkg::*;

  sample_t in_sample, smp;
  logic    smp_valid, smp_taken;
  event_e  res_event;

  assign in_sample.pressed = s_axis_tdata[0];
  assign in_sample.now_ms  = s_axis_tdata[NOW_BITS:1];

  bpc_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_sample_i (in_sample),
    .smp_valid_o (smp_valid),
    .smp_taken_i (smp_taken),
    .smp_o       (smp)
  );

  bpc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (reg_idx_e'(cfg_index_i)),
    .cfg_data_i  (cfg_data_i),
    .smp_valid_i (smp_valid),
    .smp_i       (smp),
    .smp_taken_o (smp_taken),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_event_o (res_event)
  );

  assign m_axis_tdata = {{(OUT_TDATA_BITS-2){1'b0}}, res_event};

endmodule

`default_nettype wire

// ===== rtl/bpc_in_reg.sv =====
// Input register stage of the button press classifier.
// Depends on bpc_pkg for the sample type.
`timescale 1ns / 1ps
`default_nettype none

module bpc_in_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire bpc_pkg::sample_t in_sample_i,
  output logic                  smp_valid_o,
  input  wire logic             smp_taken_i,
  output bpc_pkg::sample_t      smp_o
);
  import bpc_pkg::*;

  logic    valid_q, valid_d;
  sample_t smp_q;

  // Take a new sample whenever the held one is empty or leaves this cycle.
  assign in_ready_o = !valid_q || smp_taken_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !smp_taken_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      smp_q <= in_sample_i;
    end
  end

  assign smp_valid_o = valid_q;
  assign smp_o       = smp_q;

endmodule

`default_nettype wire

// ===== rtl/bpc_core.sv =====
// Press state, classification logic and result register.
// Depends on bpc_pkg for types, event codes and register indexes.
`timescale 1ns / 1ps
`default_nettype none

module bpc_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire bpc_pkg::reg_idx_e         cfg_index_i,
  input  wire bpc_pkg::cfg_word_t        cfg_data_i,
  input  wire logic                      smp_valid_i,
  input  wire bpc_pkg::sample_t          smp_i,
  output logic                           smp_taken_o,
  output logic                           res_valid_o,
  input  wire logic                      res_ready_i,
  output bpc_pkg::event_e                res_event_o
);
  import bpc_pkg::*;

  cfg_word_t long_q, window_q;
  logic      held_q, held_d;
  time_t     hold_start_q, hold_start_d;
  time_t     first_q, first_d;
  tally_t    tally_q, tally_d;
  logic      res_valid_q;
  event_e    ev_q, ev_d;

  logic  fire;
  time_t now, el_first, el_hold, window_t, long_t;

  assign fire        = smp_valid_i && (!res_valid_q || res_ready_i);
  assign smp_taken_o = fire;

  assign now      = time_t'(smp_i.now_ms);
  assign window_t = time_t'(window_q);
  assign long_t   = time_t'(long_q);
  assign el_first = now - first_q;
  assign el_hold  = now - hold_start_q;

  always_comb begin
    held_d       = held_q;
    hold_start_d = hold_start_q;
    first_d      = first_q;
    tally_d      = tally_q;
    ev_d         = EV_NONE;

    if (smp_i.pressed && !held_q) begin
      hold_start_d = now;
      held_d       = 1'b1;
      if (tally_q != '0 && el_first < window_t) begin
        if (tally_q != '1) begin
          tally_d = tally_q + 1'b1;
        end
      end else begin
        tally_d = tally_t'(1);
        first_d = now;
      end
    end

    if (!smp_i.pressed && held_q) begin
      held_d = 1'b0;
      if (el_hold >= long_t) begin
        ev_d    = EV_LONG;
        tally_d = '0;
      end
    end

    // Window expiry with the button up; first_q is unchanged when held_d is low.
    if (tally_d != '0 && !held_d && el_first > window_t) begin
      ev_d    = (tally_d >= tally_t'(2)) ? EV_DOUBLE : EV_SHORT;
      tally_d = '0;
    end
  end

  // The debounce register has no bearing on any result, so only the
  // long-press and window registers are held.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_q   <= LONG_PRESS_RST;
      window_q <= DOUBLE_WINDOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LONG_PRESS:    long_q   <= cfg_data_i;
        REG_DOUBLE_WINDOW: window_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q       <= 1'b0;
      hold_start_q <= '0;
      first_q      <= '0;
      tally_q      <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      if (fire) begin
        held_q       <= held_d;
        hold_start_q <= hold_start_d;
        first_q      <= first_d;
        tally_q      <= tally_d;
      end
      if (fire) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      ev_q <= ev_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_event_o = ev_q;

`ifndef NO_ASSERTIONS
  a_held_has_tally: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q |-> (tally_q != '0))
    else $error("button held with empty press tally");

  a_event_clears_tally: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && ev_d != EV_NONE) |=> (tally_q == '0))
    else $error("press tally not cleared after an event");

  a_short_double_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (ev_d == EV_SHORT || ev_d == EV_DOUBLE)) |=> !held_q)
    else $error("short or double press reported while held");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> ($stable(tally_q) && $stable(held_q) && $stable(first_q)))
    else $error("press state moved without a sample");
`endif

endmodule

`default_nettype wire

// ===== dv/button_press_classifier_top_test.sv =====
// Self-checking testbench for button_press_classifier_top: stream driver and monitor,
// an in-bench press classifier predicting every event code, and timing register phases.
// Depends on bpc_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module button_press_classifier_top_test;
  import bpc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int unsigned PHASE_SAMPLES = 50;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  reg_idx_e cfg_index_i = REG_DEBOUNCE;
  cfg_word_t cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_BITS-1:0] s_axis_tdata = '0;   // [0] pressed, [32:1] now_ms
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;        // [1:0] event_code

  button_press_classifier_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Press tracker mirror and its timing registers
  logic      held_q = 1'b0;
  time_t     hold_start_q = '0;
  time_t     first_press_q = '0;
  tally_t    tally_q = '0;
  cfg_word_t debounce_cfg = 16'd50;
  cfg_word_t long_cfg = LONG_PRESS_RST;
  cfg_word_t window_cfg = DOUBLE_WINDOW_RST;

  sample_t pending_samples[$];
  event_e  expected_events[$];
  time_t   stim_ms = '0;
  int unsigned sample_count = 0;
  int unsigned mismatches = 0;
  int unsigned cycles_run = 0;

  bit in_taken = 1'b0;
  int unsigned burst_left = 8;
  int unsigned idle_left = 0;
  sample_t next_sample;
  logic [IN_TDATA_BITS-1:0] beat;
  int unsigned rx_left = 0;
  int unsigned rx_mode = 0;
  event_e want;

  function automatic event_e classify_sample(logic down, time_t now);
    event_e code;
    code = EV_NONE;
    if (down && !held_q) begin
      hold_start_q = now;
      held_q = 1'b1;
      if (tally_q != 0 && time_t'(now - first_press_q) < window_cfg) begin
        if (tally_q != '1) tally_q = tally_q + 1'b1;   // saturate
      end else begin
        tally_q = tally_t'(1);
        first_press_q = now;
      end
    end
    if (!down && held_q) begin
      held_q = 1'b0;
      if (time_t'(now - hold_start_q) >= long_cfg) begin
        code = EV_LONG;
        tally_q = '0;
      end
    end
    // expiry may report in the same step as a short release
    if (tally_q != 0 && !held_q && time_t'(now - first_press_q) > window_cfg) begin
      code = (tally_q >= 2) ? EV_DOUBLE : EV_SHORT;
      tally_q = '0;
    end
    return code;
  endfunction

  // Sender: bursts of transfers with idle gaps between them
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (idle_left != 0) begin
        idle_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        next_sample = pending_samples.pop_front();
        beat = '0;
        beat[0] = next_sample.pressed;
        beat[NOW_BITS:1] = next_sample.now_ms;
        s_axis_tdata <= beat;
        s_axis_tvalid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 32);
          idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: runs of ready, runs of stall and runs of random back-pressure
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = (rx_mode == 1) ? $urandom_range(1, 16) : $urandom_range(1, 48);
    end
    rx_left--;
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'b0;
      default: m_axis_tready <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk_i) begin
    in_taken = s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_events.size() == 0) begin
        $error("event_code: no result expected, got %0d", m_axis_tdata[1:0]);
        mismatches++;
      end else begin
        want = expected_events.pop_front();
        if (m_axis_tdata[1:0] !== want) begin
          $error("event_code: expected %0d, got %0d", want, m_axis_tdata[1:0]);
          mismatches++;
        end
      end
    end
    if (rst_ni && in_taken)
      expected_events.push_back(classify_sample(s_axis_tdata[0],
                                                time_t'(s_axis_tdata[NOW_BITS:1])));
  end

  always @(posedge clk_i) begin
    cycles_run++;
    if (cycles_run > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic emit_at(logic down, time_t t);
    sample_t s;
    s.pressed = down;
    s.now_ms = t;
    stim_ms = t;
    pending_samples.push_back(s);
    sample_count++;
  endtask

  task automatic emit(logic down, int unsigned delta);
    emit_at(down, stim_ms + time_t'(delta));
  endtask

  // Hold for the given time, split over up to three held samples
  task automatic do_press(int unsigned hold);
    int unsigned n;
    int unsigned part;
    n = $urandom_range(0, 2);
    part = hold / (n + 1);
    emit(1'b1, $urandom_range(0, 3));
    repeat (n) emit(1'b1, part);
    emit(1'b0, hold - n * part);
  endtask

  // Bias towards a threshold and its neighbours
  function automatic int unsigned pick_near(int unsigned v);
    case ($urandom_range(0, 3))
      0: return v;
      1: return (v == 0) ? 0 : v - 1;
      2: return v + 1;
      default: return $urandom_range(0, 2 * v + 2);
    endcase
  endfunction

  // Check at the rising edge, where the sender's queue and tvalid are settled
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_samples.size() != 0 || s_axis_tvalid || expected_events.size() != 0);
  endtask

  task automatic write_reg(reg_idx_e idx, cfg_word_t val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_DEBOUNCE:      debounce_cfg = val;
      REG_LONG_PRESS:    long_cfg = val;
      REG_DOUBLE_WINDOW: window_cfg = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_timing(cfg_word_t deb, cfg_word_t hold_long, cfg_word_t win);
    wait_idle();
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_LONG_PRESS, hold_long);
    write_reg(REG_DOUBLE_WINDOW, win);
    if ($urandom_range(0, 1)) write_reg(REG_UNUSED, cfg_word_t'($urandom));
    @(posedge clk_i);
  endtask

  task automatic random_phase(int unsigned n_samples);
    int unsigned target;
    int unsigned k;
    target = sample_count + n_samples;
    while (sample_count < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          do_press(pick_near(long_cfg));
          emit(1'b0, pick_near(window_cfg));
        end
        4, 5, 6: begin
          k = $urandom_range(2, 4);
          repeat (k) begin
            do_press($urandom_range(0, window_cfg / 4));
            emit(1'b0, $urandom_range(0, window_cfg / 2));
          end
          emit(1'b0, pick_near(window_cfg));
        end
        7: repeat ($urandom_range(1, 4))
          emit(1'($urandom_range(0, 1)), $urandom_range(0, 3 * window_cfg + 3));
        8: emit_at(1'($urandom_range(0, 1)), time_t'($urandom));
        default: emit(1'b0, $urandom_range(0, 1));
      endcase
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Reset timing: long 1000, window 400
    emit_at(1'b0, 32'd0);
    emit_at(1'b1, 32'd10);
    emit_at(1'b1, 32'd40);
    emit_at(1'b0, 32'd100);
    emit_at(1'b0, 32'd410);           // exactly on the window: no report yet
    emit_at(1'b0, 32'd411);           // short press
    emit_at(1'b1, 32'd1000);
    emit_at(1'b0, 32'd2000);          // long press at the threshold
    emit_at(1'b1, 32'd3000);
    emit_at(1'b0, 32'd3999);          // just short of long, expires in the same step
    emit_at(1'b1, 32'd5000);
    emit_at(1'b0, 32'd5050);
    emit_at(1'b1, 32'd5399);          // second press inside the window
    emit_at(1'b0, 32'd5450);
    emit_at(1'b0, 32'd5801);          // double press
    emit_at(1'b1, 32'd7000);
    emit_at(1'b0, 32'd7010);
    emit_at(1'b1, 32'd7400);          // on the window edge: restart the count
    emit_at(1'b0, 32'd7401);
    emit_at(1'b0, 32'd7801);
    emit_at(1'b1, 32'hFFFF_FFFF);
    emit_at(1'b0, 32'h0000_0010);     // hold wraps through zero
    emit_at(1'b0, 32'hFFFF_FF00);     // clock steps back: huge elapsed time

    // Saturate the press count: 257 presses inside one wide window
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (257) begin
      emit(1'b1, 1);
      emit(1'b0, 1);
    end
    emit(1'b0, 70000);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_timing(16'd0, 16'd0, 16'd0);
        1: set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: set_timing(16'd50, 16'd1000, 16'd400);
        default: set_timing(cfg_word_t'($urandom),
                            cfg_word_t'($urandom_range(0, 400)),
                            cfg_word_t'($urandom_range(0, 400)));
      endcase
      random_phase(PHASE_SAMPLES);
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
